// ----- rtl/btc_pkg.sv -----
// ---------------------------------------------------------------------------
// btc_pkg: shared types and constants for barometric trim compensation
// Transaction payloads, trim word layout, inter-block structs and widths.
// ---------------------------------------------------------------------------
package btc_pkg;

  localparam int ADC_W   = 20;
  localparam int TEMP_W  = 16;
  localparam int PRESS_W = 25;
  localparam int TRIM_W  = 16;
  localparam int V_W     = 24;                 // fine temperature minus offset
  localparam int DEN_W   = 40;                 // divisor magnitude
  localparam int QUO_W   = 36;                 // quotient bits developed
  localparam int NUM_W   = DEN_W + QUO_W;      // dividend magnitude
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};
  localparam logic [QUO_W-1:0]   Q_LIMIT   = {1'b1, {(QUO_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_NINTH = 2'd3;

  typedef struct packed {
    logic [ADC_W-1:0] adc_temp;
    logic [ADC_W-1:0] adc_press;
  } in_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_centi_deg;
    logic [PRESS_W-1:0]       press_q8_pa;
    logic                     divisor_zero;
  } out_t;

  typedef struct packed {
    logic [TRIM_W-1:0]        t1;
    logic signed [TRIM_W-1:0] t2;
    logic signed [TRIM_W-1:0] t3;
    logic [TRIM_W-1:0]        p1;
    logic signed [TRIM_W-1:0] p2;
    logic signed [TRIM_W-1:0] p3;
    logic signed [TRIM_W-1:0] p4;
    logic signed [TRIM_W-1:0] p5;
    logic signed [TRIM_W-1:0] p6;
    logic signed [TRIM_W-1:0] p7;
    logic signed [TRIM_W-1:0] p8;
    logic signed [TRIM_W-1:0] p9;
  } trim_t;

  // temperature section -> coefficient section
  typedef struct packed {
    logic signed [V_W-1:0]    v;
    logic signed [TEMP_W-1:0] temp;
    logic [ADC_W-1:0]         adc_press;
  } tv_t;

  // coefficient section -> divider
  typedef struct packed {
    logic [NUM_W-1:0]         nmag;
    logic [DEN_W-1:0]         dmag;
    logic                     neg;
    logic                     dz;
    logic signed [TEMP_W-1:0] temp;
  } dvin_t;

  // divider -> correction section
  typedef struct packed {
    logic [QUO_W-1:0]         qmag;
    logic                     ovf;
    logic                     neg;
    logic                     dz;
    logic signed [TEMP_W-1:0] temp;
  } dvout_t;

endpackage

// ----- rtl/btc_temp.sv -----
// ---------------------------------------------------------------------------
// btc_temp: temperature compensation pipeline
// Four stages: offsets, products, fine temperature, scaling and saturation.
// ---------------------------------------------------------------------------
module btc_temp (
  input  logic            clk,
  input  logic            rst_n,
  input  btc_pkg::trim_t  trim,
  input  logic            in_valid,
  output logic            in_ready,
  input  btc_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output btc_pkg::tv_t    out_data
);

  localparam int NS = 4;

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;
  logic [NS-1:0] vld_in;

  assign adv[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !vld_r[i] || adv[i+1];
  end
  assign vld_in   = {vld_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv[NS-1:0] & vld_in) | (~adv[NS-1:0] & vld_r);
    end
  end

  // stage 0
  logic signed [17:0] dx_r, d_r;
  logic [btc_pkg::ADC_W-1:0] ap0_r;
  // stage 1
  logic signed [22:0] x_r;
  logic signed [20:0] dsq_r;
  logic [btc_pkg::ADC_W-1:0] ap1_r;
  // stage 2
  logic signed [23:0] tf_r;
  logic [btc_pkg::ADC_W-1:0] ap2_r;
  // stage 3
  btc_pkg::tv_t out_r;

  logic signed [17:0] dx_nxt, d_nxt;
  logic signed [33:0] xp;
  logic signed [35:0] dp;
  logic signed [36:0] yp;
  logic signed [27:0] tc, ts;
  logic signed [btc_pkg::TEMP_W-1:0] temp_nxt;

  always_comb begin
    dx_nxt = $signed({1'b0, in_data.adc_temp[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
    d_nxt  = $signed({2'b0, in_data.adc_temp[19:4]}) - $signed({2'b0, trim.t1});
    xp     = 34'(dx_r) * 34'($signed(trim.t2));
    dp     = 36'(d_r) * 36'(d_r);
    yp     = 37'(dsq_r) * 37'($signed(trim.t3));
    tc     = 28'(tf_r) * 28'sd5 + 28'sd128;
    ts     = tc >>> 8;
    if (ts > 28'sd32767) begin
      temp_nxt = 16'sd32767;
    end else if (ts < -28'sd32768) begin
      temp_nxt = -16'sd32768;
    end else begin
      temp_nxt = 16'(ts);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r  <= dx_nxt;
      d_r   <= d_nxt;
      ap0_r <= in_data.adc_press;
    end
    if (adv[1]) begin
      x_r   <= 23'(xp >>> 11);
      dsq_r <= 21'(dp >>> 12);
      ap1_r <= ap0_r;
    end
    if (adv[2]) begin
      tf_r  <= 24'(x_r) + 24'(yp >>> 14);
      ap2_r <= ap1_r;
    end
    if (adv[3]) begin
      out_r.v         <= tf_r - 24'sd128000;
      out_r.temp      <= temp_nxt;
      out_r.adc_press <= ap2_r;
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_data  = out_r;

endmodule

// ----- rtl/btc_coef.sv -----
// ---------------------------------------------------------------------------
// btc_coef: pressure polynomial and divider operand preparation
// Seven stages: products of v, trim products, sums, numerator and divisor,
// scaling by 3125 in two steps, then sign and magnitude split.
// ---------------------------------------------------------------------------
module btc_coef (
  input  logic            clk,
  input  logic            rst_n,
  input  btc_pkg::trim_t  trim,
  input  logic            in_valid,
  output logic            in_ready,
  input  btc_pkg::tv_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output btc_pkg::dvin_t  out_data
);

  localparam int NS = 7;
  localparam int TW = btc_pkg::TEMP_W;
  localparam int AW = 56;

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;
  logic [NS-1:0] vld_in;

  assign adv[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !vld_r[i] || adv[i+1];
  end
  assign vld_in   = {vld_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv[NS-1:0] & vld_in) | (~adv[NS-1:0] & vld_r);
    end
  end

  logic signed [TW-1:0] temp_r [NS-1];
  logic [btc_pkg::ADC_W-1:0] ap0_r, ap1_r, ap2_r;

  logic signed [47:0] vv_r;
  logic signed [39:0] vp5_r, vp2_r;
  logic signed [63:0] v6_r, v3_r, bp_r;
  logic signed [AW-1:0] apart_r;
  logic signed [63:0] b_r;
  logic signed [AW-1:0] a_r;
  logic signed [63:0] n_r;
  logic signed [72:0] prod_r;
  logic signed [70:0] m_r;
  logic signed [btc_pkg::DEN_W-1:0] dv4_r, dv5_r;
  logic signed [btc_pkg::NUM_W-1:0] nn_r;
  btc_pkg::dvin_t out_r;

  logic signed [63:0] base;
  logic signed [70:0] nw;
  logic signed [btc_pkg::NUM_W-1:0] mw;

  always_comb begin
    base = (64'sd1048576 - 64'($signed({1'b0, ap2_r}))) <<< 31;
    nw   = 71'(n_r);
    mw   = btc_pkg::NUM_W'(m_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      vv_r      <= 48'(in_data.v) * 48'(in_data.v);
      vp5_r     <= 40'(in_data.v) * 40'($signed(trim.p5));
      vp2_r     <= 40'(in_data.v) * 40'($signed(trim.p2));
      ap0_r     <= in_data.adc_press;
      temp_r[0] <= in_data.temp;
    end
    if (adv[1]) begin
      v6_r      <= 64'(vv_r) * 64'($signed(trim.p6));
      v3_r      <= 64'(vv_r) * 64'($signed(trim.p3));
      bp_r      <= (64'(vp5_r) <<< 17) + (64'($signed(trim.p4)) <<< 35);
      apart_r   <= (AW'(vp2_r) <<< 12) + (AW'(1) <<< 47);
      ap1_r     <= ap0_r;
      temp_r[1] <= temp_r[0];
    end
    if (adv[2]) begin
      b_r       <= v6_r + bp_r;
      a_r       <= AW'(v3_r >>> 8) + apart_r;
      ap2_r     <= ap1_r;
      temp_r[2] <= temp_r[1];
    end
    if (adv[3]) begin
      n_r       <= base - b_r;
      prod_r    <= 73'(a_r) * 73'($signed({1'b0, trim.p1}));
      temp_r[3] <= temp_r[2];
    end
    if (adv[4]) begin
      // n * 125
      m_r       <= (nw <<< 7) - (nw <<< 1) - nw;
      dv4_r     <= btc_pkg::DEN_W'(prod_r >>> 33);
      temp_r[4] <= temp_r[3];
    end
    if (adv[5]) begin
      // (n * 125) * 25
      nn_r      <= (mw <<< 4) + (mw <<< 3) + mw;
      dv5_r     <= dv4_r;
      temp_r[5] <= temp_r[4];
    end
    if (adv[6]) begin
      out_r.nmag <= nn_r[btc_pkg::NUM_W-1] ? btc_pkg::NUM_W'(-nn_r) : btc_pkg::NUM_W'(nn_r);
      out_r.dmag <= dv5_r[btc_pkg::DEN_W-1] ? btc_pkg::DEN_W'(-dv5_r)
                                            : btc_pkg::DEN_W'(dv5_r);
      out_r.neg  <= nn_r[btc_pkg::NUM_W-1] ^ dv5_r[btc_pkg::DEN_W-1];
      out_r.dz   <= (dv5_r == '0);
      out_r.temp <= temp_r[5];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_data  = out_r;

endmodule

// ----- rtl/btc_div.sv -----
// ---------------------------------------------------------------------------
// btc_div: pipelined restoring divider on magnitudes
// One overflow check stage, then one quotient bit per stage.
// ---------------------------------------------------------------------------
module btc_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  btc_pkg::dvin_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output btc_pkg::dvout_t  out_data
);

  localparam int QW = btc_pkg::QUO_W;
  localparam int DW = btc_pkg::DEN_W;
  localparam int NS = QW + 1;

  typedef struct packed {
    logic [DW-1:0]                     rem;
    logic [QW-1:0]                     nq;    // dividend bits out, quotient bits in
    logic [DW-1:0]                     dmag;
    logic                              ovf;
    logic                              neg;
    logic                              dz;
    logic signed [btc_pkg::TEMP_W-1:0] temp;
  } dstg_t;

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;
  logic [NS-1:0] vld_in;
  dstg_t         stg_r [NS];

  assign adv[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !vld_r[i] || adv[i+1];
  end
  assign vld_in   = {vld_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv[NS-1:0] & vld_in) | (~adv[NS-1:0] & vld_r);
    end
  end

  // quotient of 2^QW or more cannot fit: flagged and clamped downstream
  dstg_t init_nxt;
  always_comb begin
    init_nxt.rem  = in_data.nmag[btc_pkg::NUM_W-1 -: DW];
    init_nxt.nq   = in_data.nmag[QW-1:0];
    init_nxt.dmag = in_data.dmag;
    init_nxt.ovf  = (in_data.nmag[btc_pkg::NUM_W-1 -: DW] >= in_data.dmag);
    init_nxt.neg  = in_data.neg;
    init_nxt.dz   = in_data.dz;
    init_nxt.temp = in_data.temp;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      stg_r[0] <= init_nxt;
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    dstg_t       step_nxt;
    always_comb begin
      trial            = {stg_r[i-1].rem, stg_r[i-1].nq[QW-1]};
      ge               = (trial >= {1'b0, stg_r[i-1].dmag});
      step_nxt         = stg_r[i-1];
      step_nxt.rem     = ge ? DW'(trial - {1'b0, stg_r[i-1].dmag}) : trial[DW-1:0];
      step_nxt.nq      = {stg_r[i-1].nq[QW-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        stg_r[i] <= step_nxt;
      end
    end
  end

  assign out_valid     = vld_r[NS-1];
  assign out_data.qmag = stg_r[NS-1].nq;
  assign out_data.ovf  = stg_r[NS-1].ovf;
  assign out_data.neg  = stg_r[NS-1].neg;
  assign out_data.dz   = stg_r[NS-1].dz;
  assign out_data.temp = stg_r[NS-1].temp;

endmodule

// ----- rtl/btc_post.sv -----
// ---------------------------------------------------------------------------
// btc_post: quotient clamp, second-order corrections and pressure saturation
// Five stages; the last one is the result register.
// ---------------------------------------------------------------------------
module btc_post (
  input  logic             clk,
  input  logic             rst_n,
  input  btc_pkg::trim_t   trim,
  input  logic             in_valid,
  output logic             in_ready,
  input  btc_pkg::dvout_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output btc_pkg::out_t    out_data
);

  localparam int NS = 5;
  localparam int TW = btc_pkg::TEMP_W;
  localparam int QW = btc_pkg::QUO_W;

  logic [NS-1:0] vld_r;
  logic [NS:0]   adv;
  logic [NS-1:0] vld_in;

  assign adv[NS] = out_ready;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !vld_r[i] || adv[i+1];
  end
  assign vld_in   = {vld_r[NS-2:0], in_valid};
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (adv[NS-1:0] & vld_in) | (~adv[NS-1:0] & vld_r);
    end
  end

  logic signed [TW-1:0] temp_r [NS-1];
  logic [NS-2:0]        dz_r;
  logic signed [QW:0]   q0_r, q1_r, q2_r;
  logic signed [23:0]   qs_r;
  logic signed [47:0]   qq_r;
  logic signed [52:0]   c8p_r;
  logic signed [63:0]   c9p_r;
  logic signed [33:0]   c8_r;
  logic signed [38:0]   sum_r;
  btc_pkg::out_t        out_r;

  logic [QW-1:0]      qm;
  logic signed [QW:0] q_nxt;
  logic signed [39:0] pf;
  logic [btc_pkg::PRESS_W-1:0] press_nxt;

  always_comb begin
    qm    = (in_data.ovf || in_data.qmag > btc_pkg::Q_LIMIT) ? btc_pkg::Q_LIMIT : in_data.qmag;
    q_nxt = in_data.neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    pf    = 40'(sum_r >>> 8) + (40'($signed(trim.p7)) <<< 4);
    if (dz_r[3] || pf < 40'sd0) begin
      press_nxt = '0;
    end else if (pf > 40'($signed({1'b0, btc_pkg::PRESS_MAX}))) begin
      press_nxt = btc_pkg::PRESS_MAX;
    end else begin
      press_nxt = pf[btc_pkg::PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      q0_r      <= q_nxt;
      qs_r      <= 24'(q_nxt >>> 13);
      dz_r[0]   <= in_data.dz;
      temp_r[0] <= in_data.temp;
    end
    if (adv[1]) begin
      qq_r      <= 48'(qs_r) * 48'(qs_r);
      c8p_r     <= 53'(q0_r) * 53'($signed(trim.p8));
      q1_r      <= q0_r;
      dz_r[1]   <= dz_r[0];
      temp_r[1] <= temp_r[0];
    end
    if (adv[2]) begin
      c9p_r     <= 64'(qq_r) * 64'($signed(trim.p9));
      c8_r      <= 34'(c8p_r >>> 19);
      q2_r      <= q1_r;
      dz_r[2]   <= dz_r[1];
      temp_r[2] <= temp_r[1];
    end
    if (adv[3]) begin
      sum_r     <= 39'(q2_r) + 39'(c9p_r >>> 25) + 39'(c8_r);
      dz_r[3]   <= dz_r[2];
      temp_r[3] <= temp_r[2];
    end
    if (adv[4]) begin
      out_r.temp_centi_deg <= temp_r[3];
      out_r.press_q8_pa    <= press_nxt;
      out_r.divisor_zero   <= dz_r[3];
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_data  = out_r;

endmodule

// ----- rtl/baro_trim_compensation_top.sv -----
// ---------------------------------------------------------------------------
// baro_trim_compensation_top: barometer trim compensation pipeline
// Temperature and pressure compensation from factory trim words.
// ---------------------------------------------------------------------------
// Each input transaction carries one raw temperature and one raw pressure
// sample; each gives exactly one result transaction: temperature in 0.01 degC
// and pressure in Pa with 8 fraction bits, both saturated, plus a flag when
// the pressure divisor came out zero (pressure then reads 0). The block
// accepts one transaction per clock as long as out_ready takes the results;
// each one passes through the temperature stages, the polynomial and operand
// preparation, the divider (one quotient bit per stage, which sets the depth)
// and the correction terms, in that order. Every stage holds its own
// valid bit and moves whenever the stage ahead is empty or moving, so bubbles
// close up and in_ready stays high while a finished result waits on
// out_ready, as long as some stage is free. Trim words are written through
// the cfg port, which is always ready; write them only with the pipeline
// empty. Every two-bit index names one of the four trim registers.
// ---------------------------------------------------------------------------
module baro_trim_compensation_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input samples
  input  logic                               in_valid,
  output logic                               in_ready,
  input  btc_pkg::in_t                       in_data,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output btc_pkg::out_t                      out_data,
  // trim register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [btc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Trim registers
  logic [47:0] temp_trim_r;
  logic [63:0] press_trim_low_r;
  logic [63:0] press_trim_high_r;
  logic [15:0] press_trim_ninth_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r        <= '0;
      press_trim_low_r   <= '0;
      press_trim_high_r  <= '0;
      press_trim_ninth_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        btc_pkg::CFG_TEMP_TRIM:   temp_trim_r        <= cfg_data[47:0];
        btc_pkg::CFG_PRESS_LOW:   press_trim_low_r   <= cfg_data;
        btc_pkg::CFG_PRESS_HIGH:  press_trim_high_r  <= cfg_data;
        btc_pkg::CFG_PRESS_NINTH: press_trim_ninth_r <= cfg_data[15:0];
      endcase
    end
  end

  // Unpack the trim words once for all sections
  btc_pkg::trim_t trim;
  assign trim.t1 = temp_trim_r[15:0];
  assign trim.t2 = $signed(temp_trim_r[31:16]);
  assign trim.t3 = $signed(temp_trim_r[47:32]);
  assign trim.p1 = press_trim_low_r[15:0];
  assign trim.p2 = $signed(press_trim_low_r[31:16]);
  assign trim.p3 = $signed(press_trim_low_r[47:32]);
  assign trim.p4 = $signed(press_trim_low_r[63:48]);
  assign trim.p5 = $signed(press_trim_high_r[15:0]);
  assign trim.p6 = $signed(press_trim_high_r[31:16]);
  assign trim.p7 = $signed(press_trim_high_r[47:32]);
  assign trim.p8 = $signed(press_trim_high_r[63:48]);
  assign trim.p9 = $signed(press_trim_ninth_r);

  // Section links
  logic            tv_valid, tv_ready;
  btc_pkg::tv_t    tv_data;
  logic            dvi_valid, dvi_ready;
  btc_pkg::dvin_t  dvi_data;
  logic            dvo_valid, dvo_ready;
  btc_pkg::dvout_t dvo_data;

  // Fine temperature, saturated temperature output, offset v
  btc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .trim      (trim),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (tv_valid),
    .out_ready (tv_ready),
    .out_data  (tv_data)
  );

  // Pressure polynomial, numerator scaled by 3125, divisor
  btc_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .trim      (trim),
    .in_valid  (tv_valid),
    .in_ready  (tv_ready),
    .in_data   (tv_data),
    .out_valid (dvi_valid),
    .out_ready (dvi_ready),
    .out_data  (dvi_data)
  );

  // Truncating division on magnitudes, overflow flagged
  btc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dvi_valid),
    .in_ready  (dvi_ready),
    .in_data   (dvi_data),
    .out_valid (dvo_valid),
    .out_ready (dvo_ready),
    .out_data  (dvo_data)
  );

  // Clamp, squared and linear corrections, offset, saturation
  btc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .trim      (trim),
    .in_valid  (dvo_valid),
    .in_ready  (dvo_ready),
    .in_data   (dvo_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An empty result register means every stage can move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with result register empty");

  // Zero divisor forces pressure to zero
  a_zero_div_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divisor_zero |-> out_data.press_q8_pa == '0)
    else $error("pressure non-zero on zero divisor");

  // A P9 write lands in its register on the next edge
  a_ninth_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == btc_pkg::CFG_PRESS_NINTH
      |=> press_trim_ninth_r == $past(cfg_data[15:0]))
    else $error("P9 trim write lost");

  // A stalled result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule
